// File: design/pra_pkg.sv
package pra_pkg;

  // Width of every power value on the result channel.
  localparam int unsigned PWR_W = 48;

  // Field widths of the PMBus formats.
  localparam int unsigned VM_EXP_W   = 5;
  localparam int unsigned L11_EXP_W  = 5;
  localparam int unsigned L11_MANT_W = 11;
  localparam int unsigned VRAW_W     = 16;

  // Unsigned product of the voltage mantissa and the current magnitude.
  localparam int unsigned MAG_W = VRAW_W + L11_MANT_W;

  // Signed shift amount, exponent sum plus fraction bits.
  localparam int unsigned SH_W = 8;

  typedef logic signed [PWR_W-1:0] pwr_t;

  localparam pwr_t PWR_MAX = {1'b0, {(PWR_W-1){1'b1}}};
  localparam pwr_t PWR_MIN = {1'b1, {(PWR_W-1){1'b0}}};

  // Reset value of the rail-to-group map.
  localparam logic [31:0] MAP_RST = 32'd990020;

  typedef enum logic [1:0] {
    GRP_PL   = 2'd0,
    GRP_PS   = 2'd1,
    GRP_DDR  = 2'd2,
    GRP_MISC = 2'd3
  } grp_t;

  localparam int unsigned NUM_GRP = 4;

  // Control that travels with a rail power word toward the accumulators.
  typedef struct packed {
    logic first;
    logic last;
    logic add;
    logic fail;
    grp_t grp;
  } rail_ctl_t;

  // Saturating add over the power range.
  function automatic pwr_t sat_add(input pwr_t a, input pwr_t b);
    logic signed [PWR_W:0] s;
    s = {a[PWR_W-1], a} + {b[PWR_W-1], b};
    if (s[PWR_W] != s[PWR_W-1]) begin
      sat_add = s[PWR_W] ? PWR_MIN : PWR_MAX;
    end else begin
      sat_add = s[PWR_W-1:0];
    end
  endfunction

endpackage

// File: design/pra_rail_watts.sv
module pra_rail_watts import pra_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic [7:0]  volt_mode,
  input  logic [15:0] vout_raw,
  input  logic [15:0] iout_raw,
  output pwr_t        rail_power
);

  localparam int unsigned WIDE_W = MAG_W + PWR_W;

  logic signed [VM_EXP_W-1:0]   ve;
  logic signed [L11_EXP_W-1:0]  ie;
  logic signed [L11_MANT_W-1:0] im;
  logic                         neg;
  logic [L11_MANT_W-1:0]        im_mag;
  logic [MAG_W-1:0]             mag;
  logic signed [SH_W-1:0]       sh;
  logic [SH_W-1:0]              k;
  logic [WIDE_W-1:0]            wide;
  logic [WIDE_W-1:0]            lim;
  logic [MAG_W:0]               rnd;
  logic [MAG_W:0]               biased;
  logic [PWR_W-1:0]             val;

  // Decode the exponents and the Linear11 mantissa.
  assign ve     = volt_mode[VM_EXP_W-1:0];
  assign ie     = iout_raw[15:L11_MANT_W];
  assign im     = iout_raw[L11_MANT_W-1:0];
  assign neg    = im[L11_MANT_W-1];
  assign im_mag = neg ? L11_MANT_W'(-im) : L11_MANT_W'(im);

  // Magnitude product and the binary point shift.
  assign mag = MAG_W'(vout_raw) * MAG_W'(im_mag);
  assign sh  = SH_W'(ve) + SH_W'(ie) + SH_W'(FRAC_BITS);
  assign k   = SH_W'(-sh);

  // Scale and saturate; negative values round toward minus infinity.
  always_comb begin
    wide   = '0;
    rnd    = '0;
    biased = '0;
    lim    = neg ? (WIDE_W'(1) << (PWR_W - 1)) : WIDE_W'(PWR_MAX);
    if (mag == '0) begin
      val = '0;
    end else if (!sh[SH_W-1]) begin
      if (sh >= SH_W'(PWR_W)) begin
        val = lim[PWR_W-1:0];
      end else begin
        wide = WIDE_W'(mag) << sh[5:0];
        val  = (wide > lim) ? lim[PWR_W-1:0] : wide[PWR_W-1:0];
      end
    end else begin
      if (k >= SH_W'(MAG_W)) begin
        val = neg ? PWR_W'(1) : '0;
      end else begin
        rnd    = neg ? ((MAG_W+1)'(1) << k[4:0]) - (MAG_W+1)'(1) : '0;
        biased = (MAG_W+1)'(mag) + rnd;
        val    = PWR_W'(biased >> k[4:0]);
      end
    end
  end

  assign rail_power = neg ? -pwr_t'(val) : pwr_t'(val);

endmodule

// File: design/pmbus_rail_power_accumulator.sv
// Takes one word of PMBus readings per rail (the voltage mode byte, READ_VOUT as ULINEAR16
// and READ_IOUT as Linear11) and returns one result word per input word: the rail's power in
// signed fixed point with FRAC_BITS fraction bits, and the running scan total and the PL,
// PS, DDR and MISC group sums after that rail, all saturated to 48 bits. A word with
// first_rail set clears the sums and sets scan_ok before its rail is added; a failed read
// adds nothing and, if its index is below MAX_RAILS, clears scan_ok; a rail index at or
// above MAX_RAILS adds nothing. The block takes one word per clock while in_stall is low;
// a word passes through an input register, a stage that decodes, multiplies and scales,
// and the accumulator stage whose registers drive the outputs. in_stall follows out_stall
// in the same cycle once all three stages hold words. cfg_data sets the rail-to-group map
// (two bits per rail); the user must write it only while no word is in flight, which the
// block itself does not enforce, and cfg_ready is always high.
module pmbus_rail_power_accumulator import pra_pkg::*; #(
  parameter int MAX_RAILS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_rail_index,
  input  logic        in_first_rail,
  input  logic        in_last_rail,
  input  logic        in_read_ok,
  input  logic [7:0]  in_volt_mode,
  input  logic [15:0] in_vout_raw,
  input  logic [15:0] in_iout_raw,

  output logic        out_valid,
  input  logic        out_stall,
  output pwr_t        out_rail_power,
  output pwr_t        out_total_power,
  output pwr_t        out_pl_power,
  output pwr_t        out_ps_power,
  output pwr_t        out_ddr_power,
  output pwr_t        out_misc_power,
  output logic        out_scan_ok,
  output logic        out_scan_done,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] map_r;

  logic        s1_valid_r;
  logic [3:0]  s1_idx_r;
  logic        s1_first_r;
  logic        s1_last_r;
  logic        s1_rok_r;
  logic [7:0]  s1_vmode_r;
  logic [15:0] s1_vraw_r;
  logic [15:0] s1_iraw_r;

  logic        s2_valid_r;
  rail_ctl_t   s2_ctl_r;
  rail_ctl_t   s2_ctl_nxt;
  pwr_t        s2_power_r;
  pwr_t        s2_power_nxt;
  pwr_t        watts;
  logic        in_range;

  logic        out_valid_r;
  pwr_t        rail_power_r;
  pwr_t        total_r;
  pwr_t        total_nxt;
  pwr_t        grp_r   [NUM_GRP];
  pwr_t        grp_nxt [NUM_GRP];
  logic        ok_r;
  logic        ok_nxt;
  logic        done_r;

  logic        out_free;
  logic        s2_free;
  logic        s1_free;
  logic        adv3;
  logic        adv2;

  // Flow control: each stage loads when its successor has room.
  assign out_free = !out_valid_r || !out_stall;
  assign adv3     = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign adv2     = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;

  assign cfg_ready = 1'b1;

  // Group map register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= MAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      map_r <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_idx_r   <= in_rail_index;
      s1_first_r <= in_first_rail;
      s1_last_r  <= in_last_rail;
      s1_rok_r   <= in_read_ok;
      s1_vmode_r <= in_volt_mode;
      s1_vraw_r  <= in_vout_raw;
      s1_iraw_r  <= in_iout_raw;
    end
  end

  // Rail power decode and scaling.
  pra_rail_watts #(
    .FRAC_BITS (FRAC_BITS)
  ) u_watts (
    .volt_mode  (s1_vmode_r),
    .vout_raw   (s1_vraw_r),
    .iout_raw   (s1_iraw_r),
    .rail_power (watts)
  );

  assign in_range = 5'(s1_idx_r) < 5'(MAX_RAILS);

  always_comb begin
    s2_ctl_nxt.first = s1_first_r;
    s2_ctl_nxt.last  = s1_last_r;
    s2_ctl_nxt.add   = in_range && s1_rok_r;
    s2_ctl_nxt.fail  = in_range && !s1_rok_r;
    s2_ctl_nxt.grp   = grp_t'(map_r[{s1_idx_r, 1'b0} +: 2]);
    s2_power_nxt     = s2_ctl_nxt.add ? watts : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_ctl_r   <= s2_ctl_nxt;
      s2_power_r <= s2_power_nxt;
    end
  end

  // Accumulators: a new scan starts from zero with ok set.
  always_comb begin
    pwr_t base;
    total_nxt = s2_ctl_r.first ? '0 : total_r;
    if (s2_ctl_r.add) begin
      total_nxt = sat_add(total_nxt, s2_power_r);
    end
    for (int g = 0; g < NUM_GRP; g++) begin
      base       = s2_ctl_r.first ? '0 : grp_r[g];
      grp_nxt[g] = (s2_ctl_r.add && s2_ctl_r.grp == grp_t'(2'(g))) ?
                   sat_add(base, s2_power_r) : base;
    end
    ok_nxt = s2_ctl_r.first ? 1'b1 : ok_r;
    if (s2_ctl_r.fail) begin
      ok_nxt = 1'b0;
    end
  end

  // Result register; the sums live here and drive the outputs directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
      ok_r        <= 1'b1;
      for (int g = 0; g < NUM_GRP; g++) begin
        grp_r[g] <= '0;
      end
    end else begin
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
      if (adv3) begin
        total_r <= total_nxt;
        ok_r    <= ok_nxt;
        for (int g = 0; g < NUM_GRP; g++) begin
          grp_r[g] <= grp_nxt[g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      rail_power_r <= s2_power_r;
      done_r       <= s2_ctl_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rail_power  = rail_power_r;
  assign out_total_power = total_r;
  assign out_pl_power    = grp_r[GRP_PL];
  assign out_ps_power    = grp_r[GRP_PS];
  assign out_ddr_power   = grp_r[GRP_DDR];
  assign out_misc_power  = grp_r[GRP_MISC];
  assign out_scan_ok     = ok_r;
  assign out_scan_done   = done_r;

  // An empty pipeline never holds off the input.
  a_idle_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !s2_valid_r && !out_valid_r) |-> !in_stall)
    else $error("input stalled while the pipeline is empty");

  // A failed read of a rail in range leaves scan_ok low on its result.
  a_fail_clears_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (adv3 && s2_ctl_r.fail) |=> !out_scan_ok)
    else $error("scan_ok still set after a failed read");

  // A word that adds nothing and starts no scan keeps the total.
  a_total_held: assert property (@(posedge clk) disable iff (!rst_n)
    (adv3 && !s2_ctl_r.first && !s2_ctl_r.add) |=> $stable(out_total_power))
    else $error("total changed on a word that adds nothing");

endmodule
